/* design/assert_macros.svh */
// Assertion macros used by the checker file of the rotate engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, muted in reset.
`define IR90_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ir90 check failed");

// Next-cycle implication, sampled on the rising clock, muted in reset.
`define IR90_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ir90 check failed");

`endif

/* design/ir90_pkg.sv */
// Package for the rotate engine: widths, codes, result descriptor, helpers.
package ir90_pkg;

  // Fixed field widths of the streams.
  localparam int PIX_W     = 24;
  localparam int COORD_W   = 9;
  localparam int STATUS_W  = 2;

  // Configuration port.
  localparam int CFG_BITS      = 10;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_BITS-1:0] CFG_DIM_RESET = 10'd512;

  // Default geometry.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_PIXEL_BITS = 24;

  // Register indexes (word address bit).
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 2'd2;

  // Descriptor of the result a word produces.
  typedef struct packed {
    logic                has_res;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Bits needed to index n entries, at least one.
  function automatic int idx_bits(input int n);
    return ($clog2(n) > 0) ? $clog2(n) : 1;
  endfunction

  // Register value to usable dimension: zero acts as 1, above max as max.
  function automatic int clamp_dim(input logic [CFG_BITS-1:0] v, input int max_dim);
    int res;
    res = int'(v);
    if (res == 0) begin
      res = 1;
    end else if (res > max_dim) begin
      res = max_dim;
    end
    return res;
  endfunction

endpackage

/* design/ir90_stream_if.sv */
// Valid/ready stream interfaces for source words and rotated result words.
interface ir90_in_if;
  import ir90_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface ir90_out_if;
  import ir90_pkg::*;
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_out;
  logic [COORD_W-1:0]  out_row;
  logic [COORD_W-1:0]  out_col;
  logic                last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output last, output status, input ready);
  modport sink   (input valid, input pixel_out, input out_row, input out_col,
                  input last, input status, output ready);
endinterface

/* design/ir90_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
module ir90_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ir90_pkg::idx_bits(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [ir90_pkg::idx_bits(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* design/ir90_cfg.sv */
// APB register file: image width and height, clamped dimensions, rearm strobe.
module ir90_cfg #(
  parameter int MAX_WIDTH  = ir90_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ir90_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ir90_pkg::CFG_ADDR_BITS-1:0]     paddr,
  input  logic [ir90_pkg::CFG_DATA_BITS-1:0]     pwdata,
  output logic [ir90_pkg::CFG_DATA_BITS-1:0]     prdata,
  output logic                                   pready,
  output logic [$clog2(MAX_WIDTH+1)-1:0]         eff_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]        eff_h,
  output logic                                   rearm
);
  import ir90_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_BITS-1:0] width_r, height_r;
  logic [WW-1:0]       eff_w_r;
  logic [HW-1:0]       eff_h_r;
  logic                wr_en;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign rearm   = wr_en;
  assign eff_w   = eff_w_r;
  assign eff_h   = eff_h_r;

  // Raw registers plus their clamped copies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_DIM_RESET;
      height_r <= CFG_DIM_RESET;
      eff_w_r  <= WW'(clamp_dim(CFG_DIM_RESET, MAX_WIDTH));
      eff_h_r  <= HW'(clamp_dim(CFG_DIM_RESET, MAX_HEIGHT));
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH: begin
          width_r <= pwdata[CFG_BITS-1:0];
          eff_w_r <= WW'(clamp_dim(pwdata[CFG_BITS-1:0], MAX_WIDTH));
        end
        REG_HEIGHT: begin
          height_r <= pwdata[CFG_BITS-1:0];
          eff_h_r  <= HW'(clamp_dim(pwdata[CFG_BITS-1:0], MAX_HEIGHT));
        end
        default: begin
          width_r <= width_r;
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = CFG_DATA_BITS'(width_r);
      REG_HEIGHT: prdata = CFG_DATA_BITS'(height_r);
      default:    prdata = '0;
    endcase
  end
endmodule

/* design/ir90_seq.sv */
// Address sequencer: source write counters and rotated read walk over the store.
module ir90_seq #(
  parameter int MAX_WIDTH  = ir90_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ir90_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = ir90_pkg::DEF_PIXEL_BITS
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                        eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]                       eff_h,
  input  logic                                                  rearm,
  input  logic                                                  acc,
  input  logic                                                  mode,
  input  logic [ir90_pkg::PIX_W-1:0]                            pixel_in,
  output logic                                                  ram_we,
  output logic [ir90_pkg::idx_bits(MAX_WIDTH*MAX_HEIGHT)-1:0]   ram_waddr,
  output logic [PIXEL_BITS-1:0]                                 ram_wdata,
  output logic                                                  ram_re,
  output logic [ir90_pkg::idx_bits(MAX_WIDTH*MAX_HEIGHT)-1:0]   ram_raddr,
  output ir90_pkg::res_t                                        res
);
  import ir90_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = idx_bits(MAX_WIDTH);
  localparam int RW = idx_bits(MAX_HEIGHT);
  localparam int AW = idx_bits(MAX_WIDTH * MAX_HEIGHT);

  // Write side: column within row, row count (eff_h means full), linear address
  logic [CW-1:0] wcol_r, wcol_nxt;
  logic [HW-1:0] wrow_r, wrow_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  // Read side: rotated row/col, start of the current source column, address
  logic [CW-1:0] rrow_r, rrow_nxt;
  logic [RW-1:0] rcol_r, rcol_nxt;
  logic [AW-1:0] cstart_r, cstart_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;

  logic full, wcol_end, rcol_end, rrow_end;

  assign full     = (wrow_r == eff_h);
  assign wcol_end = (WW'(wcol_r) == eff_w - WW'(1));
  assign rcol_end = (HW'(rcol_r) == eff_h - HW'(1));
  assign rrow_end = (WW'(rrow_r) == eff_w - WW'(1));

  assign ram_waddr = waddr_r;
  assign ram_wdata = PIXEL_BITS'(pixel_in);
  assign ram_raddr = raddr_r;

  // Next-state and result decode for the accepted word
  always_comb begin
    wcol_nxt   = wcol_r;
    wrow_nxt   = wrow_r;
    waddr_nxt  = waddr_r;
    rrow_nxt   = rrow_r;
    rcol_nxt   = rcol_r;
    cstart_nxt = cstart_r;
    raddr_nxt  = raddr_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    res        = '0;

    if (acc) begin
      if (!mode) begin
        if (!full) begin
          // store, and remember each row start: the last one is where reading begins
          ram_we    = 1'b1;
          waddr_nxt = waddr_r + AW'(1);
          if (wcol_r == '0) begin
            cstart_nxt = waddr_r;
            raddr_nxt  = waddr_r;
          end
          if (wcol_end) begin
            wcol_nxt = '0;
            wrow_nxt = wrow_r + HW'(1);
          end else begin
            wcol_nxt = wcol_r + CW'(1);
          end
        end else begin
          res.has_res = 1'b1;
          res.status  = ST_DROPPED;
        end
      end else if (!full) begin
        res.has_res = 1'b1;
        res.status  = ST_NOT_LOADED;
      end else begin
        // emit: walk up the source column, then step to the next column
        ram_re      = 1'b1;
        res.has_res = 1'b1;
        res.status  = ST_OK;
        res.row     = COORD_W'(rrow_r);
        res.col     = COORD_W'(rcol_r);
        if (rcol_end) begin
          rcol_nxt = '0;
          if (rrow_end) begin
            res.last  = 1'b1;
            wcol_nxt  = '0;
            wrow_nxt  = '0;
            waddr_nxt = '0;
            rrow_nxt  = '0;
          end else begin
            rrow_nxt   = rrow_r + CW'(1);
            cstart_nxt = cstart_r + AW'(1);
            raddr_nxt  = cstart_r + AW'(1);
          end
        end else begin
          rcol_nxt  = rcol_r + RW'(1);
          raddr_nxt = raddr_r - AW'(eff_w);
        end
      end
    end

    // register write restarts the frame
    if (rearm) begin
      wcol_nxt  = '0;
      wrow_nxt  = '0;
      waddr_nxt = '0;
      rrow_nxt  = '0;
      rcol_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r  <= '0;
      wrow_r  <= '0;
      waddr_r <= '0;
      rrow_r  <= '0;
      rcol_r  <= '0;
    end else begin
      wcol_r  <= wcol_nxt;
      wrow_r  <= wrow_nxt;
      waddr_r <= waddr_nxt;
      rrow_r  <= rrow_nxt;
      rcol_r  <= rcol_nxt;
    end
  end

  // Read addresses are loaded while storing, before any read uses them
  always_ff @(posedge clk) begin
    cstart_r <= cstart_nxt;
    raddr_r  <= raddr_nxt;
  end
endmodule

/* design/image_rotate_90.sv */
// Top level of the 90-degree clockwise image rotate engine.
// Source pixels (mode 0) are written row-major into a single frame store of
// MAX_WIDTH*MAX_HEIGHT words; once W*H pixels are in, each mode 1 word reads
// the next pixel of the rotated W-row by H-column image. The engine takes one
// word per clock unless the input stalls; a result is registered in the read
// stage during the frame-store read, then in the output register. While a
// finished result waits to be taken, stores are still accepted and one more
// result-producing word may enter the read stage; after that the input stalls
// until the output is taken. Words beyond the frame give status 2, reads of an
// incomplete frame give status 1. The frame store needs no clearing pass after
// reset: only written entries are ever read.
// Writing either size register restarts the frame.
module image_rotate_90 #(
  parameter int MAX_WIDTH  = ir90_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ir90_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = ir90_pkg::DEF_PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  ir90_in_if.sink                            in_ch,
  ir90_out_if.source                         out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ir90_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [ir90_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [ir90_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import ir90_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = idx_bits(DEPTH);

  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;
  logic                  rearm;
  logic                  acc;
  logic                  out_free;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PIXEL_BITS-1:0] ram_wdata, ram_rdata;
  res_t                  res;

  // Read stage and output register
  logic                  s1_v_r;
  res_t                  s1_res_r;
  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_pix_r;
  logic [COORD_W-1:0]    out_row_r, out_col_r;
  logic                  out_last_r;
  logic [STATUS_W-1:0]   out_status_r;

  ir90_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff_w   (eff_w),
    .eff_h   (eff_h),
    .rearm   (rearm)
  );

  ir90_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .rearm     (rearm),
    .acc       (acc),
    .mode      (in_ch.mode),
    .pixel_in  (in_ch.pixel_in),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .res       (res)
  );

  ir90_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake: the read stage drains whenever the output register can load
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || out_free;
  assign acc         = in_ch.valid && in_ch.ready;

  // Read stage: holds the result descriptor while the RAM read completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= res.has_res;
    end else if (out_free) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r <= res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_v_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && out_free) begin
      out_pix_r    <= (s1_res_r.status == ST_OK) ? PIX_W'(ram_rdata) : '0;
      out_row_r    <= s1_res_r.row;
      out_col_r    <= s1_res_r.col;
      out_last_r   <= s1_res_r.last;
      out_status_r <= s1_res_r.status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.status    = out_status_r;
endmodule

/* design/ir90_checker.sv */
// Port-level checker for the rotate engine, bound to the top level.
`include "assert_macros.svh"

module ir90_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ir90_pkg::PIX_W-1:0]     pixel_out,
  input logic                           last,
  input logic [ir90_pkg::STATUS_W-1:0]  status
);
  import ir90_pkg::*;

  // A stalled result word stays put
  `IR90_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(status))

  // Error words carry no pixel and no end-of-frame mark
  `IR90_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (status != ST_OK), (pixel_out == '0) && !last)

  // End of frame only on a good pixel
  `IR90_ASSERT_NOW(a_last_ok, clk, rst_n, out_valid && last, status == ST_OK)

  // Input only stalls behind a result that is itself stalled
  `IR90_ASSERT_NOW(a_stall_src, clk, rst_n, !in_ready, out_valid && !out_ready)
endmodule

bind image_rotate_90 ir90_checker u_ir90_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .pixel_out (out_ch.pixel_out),
  .last      (out_ch.last),
  .status    (out_ch.status)
);

/* test/image_rotate_90_tb.sv */
// Testbench for the 90-degree rotate engine: directed table, random frames, self-checking.
`timescale 1ns / 100ps

module image_rotate_90_tb;
  import ir90_pkg::*;

  localparam int          MAX_W            = DEF_MAX_WIDTH;
  localparam int          MAX_H            = DEF_MAX_HEIGHT;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          RANDOM_WORDS     = 470;
  localparam int unsigned RUN_LIMIT_CYCLES = 500000;

  // Word modes on the input channel.
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // One rotated output word.
  typedef struct packed {
    logic [PIX_W-1:0]    pix;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
    logic [STATUS_W-1:0] status;
  } rot_word_t;

  localparam rot_word_t NO_WORD         = '0;
  localparam rot_word_t NOT_LOADED_WORD = '{'0, '0, '0, 1'b0, ST_NOT_LOADED};
  localparam rot_word_t DROPPED_WORD    = '{'0, '0, '0, 1'b0, ST_DROPPED};

  typedef enum {ROW_CFG, ROW_WORD} row_kind_t;
  typedef enum {RX_OPEN, RX_PATTERN, RX_RANDOM} rx_style_t;

  // Directed row: register write (sel = register, data = value) or a word
  // (sel = mode, data = pixel); want is used only when fixed is set.
  typedef struct {
    row_kind_t        kind;
    logic             sel;
    logic [PIX_W-1:0] data;
    bit               fixed;
    rot_word_t        want;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  ir90_in_if  in_bus ();
  ir90_out_if out_bus ();

  image_rotate_90 dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rot_word_t   rot_q[$];
  int          err_count   = 0;
  int unsigned cyc         = 0;
  bit          hold_req    = 1'b0;
  int          burst_left  = 0;
  int unsigned words_sent  = 0;

  // Predictor state.
  logic [CFG_BITS-1:0] cfg_w       = CFG_DIM_RESET;
  logic [CFG_BITS-1:0] cfg_h       = CFG_DIM_RESET;
  int unsigned         loaded_px   = 0;
  int unsigned         rd_row      = 0;
  int unsigned         rd_col      = 0;
  int unsigned         frames_done = 0;
  bit [PIX_W-1:0]      frame_mem [MAX_W*MAX_H];

  stim_row_t dir_rows [28] = '{
    // 512 x 512 after reset: reads before the frame is loaded
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b1, NOT_LOADED_WORD},
    '{ROW_WORD, MODE_STORE, 24'hFFFFFF, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h5A5A5A, 1'b1, NOT_LOADED_WORD},
    // zero sizes act as a 1 x 1 frame
    '{ROW_CFG,  REG_WIDTH,  24'd0,      1'b0, NO_WORD},
    '{ROW_CFG,  REG_HEIGHT, 24'd0,      1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'hA5A5A5, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b1, '{24'hA5A5A5, 9'd0, 9'd0, 1'b1, ST_OK}},
    '{ROW_WORD, MODE_STORE, 24'hFFFFFF, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'hFFFFFF, 1'b1, '{24'hFFFFFF, 9'd0, 9'd0, 1'b1, ST_OK}},
    '{ROW_WORD, MODE_STORE, 24'h123456, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h654321, 1'b1, DROPPED_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b1, '{24'h123456, 9'd0, 9'd0, 1'b1, ST_OK}},
    // 2 wide, 3 high: full rotation plus one dropped word
    '{ROW_CFG,  REG_WIDTH,  24'd2,      1'b0, NO_WORD},
    '{ROW_CFG,  REG_HEIGHT, 24'd3,      1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h111111, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h222222, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h333333, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h444444, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h555555, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h666666, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_STORE, 24'h777777, 1'b1, DROPPED_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD},
    '{ROW_WORD, MODE_READ,  24'h000000, 1'b0, NO_WORD}
  };

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned dim_used(input logic [CFG_BITS-1:0] v, input int lim);
    if (v == '0) begin
      return 1;
    end
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic int unsigned frame_pixels();
    return dim_used(cfg_w, MAX_W) * dim_used(cfg_h, MAX_H);
  endfunction

  function automatic void restart_frame();
    loaded_px = 0;
    rd_row    = 0;
    rd_col    = 0;
  endfunction

  // Applies one accepted word; returns 1 when it produces an output word.
  function automatic bit rotate_step(input logic m, input logic [PIX_W-1:0] p,
                                     output rot_word_t w);
    int unsigned fw;
    int unsigned fh;
    fw = dim_used(cfg_w, MAX_W);
    fh = dim_used(cfg_h, MAX_H);
    w  = '0;
    if (m == MODE_STORE) begin
      if (loaded_px < fw * fh) begin
        frame_mem[loaded_px] = p;
        loaded_px++;
        return 1'b0;
      end
      w.status = ST_DROPPED;
      return 1'b1;
    end
    if (loaded_px < fw * fh) begin
      w.status = ST_NOT_LOADED;
      return 1'b1;
    end
    // rotated (r,c) comes from source row h-1-c, column r
    w.pix    = frame_mem[(fh - 1 - rd_col) * fw + rd_row];
    w.row    = COORD_W'(rd_row);
    w.col    = COORD_W'(rd_col);
    w.status = ST_OK;
    rd_col++;
    if (rd_col >= fh) begin
      rd_col = 0;
      rd_row++;
      if (rd_row >= fw) begin
        w.last = 1'b1;
        restart_frame();
        frames_done++;
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- helpers

  task automatic flag_error(input string what, input logic [31:0] want, input logic [31:0] got);
    err_count++;
    if (err_count <= 10) begin
      $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, want, got, cyc);
    end
  endtask

  // Offer one word in burst/gap fashion; predict on acceptance.
  task automatic send_word(input logic m, input logic [PIX_W-1:0] p, input bit fixed,
                           input rot_word_t fixed_word);
    int        gap;
    bit        got;
    rot_word_t w;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                               : $urandom_range(1, 24);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= m;
    in_bus.pixel_in <= p;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
    got = rotate_step(m, p, w);
    if (got) begin
      rot_q.push_back(fixed ? fixed_word : w);
    end
    burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering, wait for every expected word, then let the pipeline settle.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (rot_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a readback of the same register.
  task automatic cfg_write(input logic idx, input logic [CFG_BITS-1:0] value);
    logic [CFG_DATA_BITS-1:0] noise;
    logic [CFG_DATA_BITS-1:0] rd;
    noise = $urandom;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {noise[CFG_DATA_BITS-1:CFG_BITS], value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (idx == REG_WIDTH) begin
      cfg_w = value;
    end else begin
      cfg_h = value;
    end
    restart_frame();
    // back-to-back read setup
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rd = prdata;
    if (rd !== CFG_DATA_BITS'(value)) begin
      flag_error("register readback", CFG_DATA_BITS'(value), rd);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_dim();
    if ($urandom_range(0, 7) == 0) begin
      return '0;
    end
    if ($urandom_range(0, 15) == 0) begin
      return CFG_BITS'($urandom_range(7, 9));
    end
    return CFG_BITS'($urandom_range(1, 6));
  endfunction

  // Mostly well-formed traffic: load the frame, then read it out, with
  // occasional early reads and dropped words mixed in.
  task automatic drive_words(input int n, input bit stop_at_frame_end);
    int unsigned goal;
    logic        m;
    goal = frames_done + 1;
    for (int i = 0; i < n; i++) begin
      if (loaded_px < frame_pixels()) begin
        m = ($urandom_range(0, 11) == 0) ? MODE_READ : MODE_STORE;
      end else begin
        m = ($urandom_range(0, 9) == 0) ? MODE_STORE : MODE_READ;
      end
      send_word(m, PIX_W'($urandom), 1'b0, NO_WORD);
      if (stop_at_frame_end && frames_done >= goal) begin
        break;
      end
    end
  endtask

  // ---------------------------------------------------------------- processes

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // cycle limit
  initial begin : watchdog
    while (cyc < RUN_LIMIT_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("status: fail");
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : result_sink
    int          seg_left;
    rx_style_t   style;
    logic [15:0] pat;
    seg_left      = 0;
    style         = RX_OPEN;
    pat           = '1;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        style    = rx_style_t'($urandom_range(0, 2));
        pat      = $urandom;
      end
      seg_left--;
      case (style)
        RX_OPEN: begin
          out_bus.ready <= 1'b1;
        end
        RX_PATTERN: begin
          out_bus.ready <= pat[seg_left % 16];
        end
        default: begin
          out_bus.ready <= ($urandom_range(0, 2) != 0);
        end
      endcase
    end
  end

  // compare each taken word with the oldest expectation
  initial begin : result_check
    rot_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (rot_q.size() == 0) begin
          flag_error("word with none expected", '0, {out_bus.status, out_bus.pixel_out});
        end else begin
          want = rot_q.pop_front();
          if (out_bus.pixel_out !== want.pix) flag_error("pixel_out", want.pix, out_bus.pixel_out);
          if (out_bus.out_row !== want.row) flag_error("out_row", want.row, out_bus.out_row);
          if (out_bus.out_col !== want.col) flag_error("out_col", want.col, out_bus.out_col);
          if (out_bus.last !== want.last) flag_error("last", want.last, out_bus.last);
          if (out_bus.status !== want.status) flag_error("status", want.status, out_bus.status);
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned rand_base;
    bit          first_phase;
    in_bus.valid    = 1'b0;
    in_bus.mode     = MODE_STORE;
    in_bus.pixel_in = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_n           = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        cfg_write(dir_rows[i].sel, dir_rows[i].data[CFG_BITS-1:0]);
      end else begin
        send_word(dir_rows[i].sel, dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // random phases; the first one runs against a long receiver hold-off
    rand_base   = words_sent;
    first_phase = 1'b1;
    while (words_sent - rand_base < RANDOM_WORDS) begin
      drain_results();
      if (first_phase) begin
        cfg_write(REG_WIDTH, 10'd1);
        cfg_write(REG_HEIGHT, 10'd2);
        hold_req = 1'b1;
        drive_words(40, 1'b0);
      end else begin
        cfg_write(REG_WIDTH, pick_dim());
        if ($urandom_range(0, 1) == 0) begin
          cfg_write(REG_HEIGHT, pick_dim());
        end
        drive_words($urandom_range(1, 3) * 2 * frame_pixels() + $urandom_range(0, 4), 1'b0);
      end
      first_phase = 1'b0;
    end

    drain_results();
    if (err_count == 0 && rot_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
